// ===== src/lens_distort_project_unit_macros.svh =====
// Assertion macros shared by the lens projection RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef LENS_DISTORT_PROJECT_UNIT_MACROS_SVH
`define LENS_DISTORT_PROJECT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, quiet while reset is held
`define LDE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lens projection check failed");

// clocked check that also runs through reset
`define LDE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lens projection reset check failed");

`else

`define LDE_ASSERT(lbl, prop)
`define LDE_ASSERT_RST(lbl, prop)

`endif

`endif

// ===== src/lde_pkg.sv =====
package lde_pkg;

  // fixed point layout
  localparam int ACC_W     = 64;
  localparam int FIELD_W   = 32;
  localparam int FRAC_NORM = 28;
  localparam int FRAC_PIX  = 16;

  // latency of one rounded, saturated product
  localparam int MUL_LAT = 5;

  localparam int COORD_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic signed [ACC_W-1:0] ONE_Q28 = 64'sd268435456;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL    = 3'd0,
    REG_PRINCIPAL = 3'd1,
    REG_SKEW     = 3'd2,
    REG_K1K2     = 3'd3,
    REG_K3       = 3'd4,
    REG_P1P2     = 3'd5,
    REG_SCALE    = 3'd6
  } cfg_reg_t;

  // coefficient set handed to the datapath
  typedef struct packed {
    logic        [FIELD_W-1:0] fx;
    logic        [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] sk;
    logic signed [FIELD_W-1:0] k1;
    logic signed [FIELD_W-1:0] k2;
    logic signed [FIELD_W-1:0] k3;
    logic signed [FIELD_W-1:0] p1;
    logic signed [FIELD_W-1:0] p2;
    logic        [FIELD_W-1:0] sr;
  } coef_t;

  // signed add clipped to the 64-bit range
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0]   s;
    logic signed [ACC_W-1:0] r;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/lde_delay.sv =====
// Plain shift line to align a value with the arithmetic pipeline.
module lde_delay #(
  parameter int W     = 64,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    sh_r[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      sh_r[i] <= sh_r[i-1];
    end
  end

  assign q_o = sh_r[DEPTH-1];

endmodule

// ===== src/lde_mulq.sv =====
// Pipelined signed product: exact, shifted right by SHIFT with rounding
// half away from zero, clipped to the signed 64-bit range.
// Stages: magnitude, 32x32 partial products, partial sum, round/clip, sign.
module lde_mulq #(
  parameter int AW    = 32,
  parameter int BW    = 32,
  parameter int SHIFT = 28
) (
  input  logic                             clk,
  input  logic signed [AW-1:0]             a_i,
  input  logic signed [BW-1:0]             b_i,
  output logic signed [lde_pkg::ACC_W-1:0] p_o
);

  localparam int CW = 32;
  localparam int NA = (AW + CW - 1) / CW;
  localparam int NB = (BW + CW - 1) / CW;
  localparam int PW = CW * (NA + NB);
  localparam int TW = PW - (lde_pkg::ACC_W - 1);
  localparam int RW = lde_pkg::ACC_W;
  localparam logic [PW-1:0] HALF    = PW'(1) << (SHIFT - 1);
  localparam logic [RW-1:0] POS_LIM = {1'b0, {(RW-1){1'b1}}};
  localparam logic [RW-1:0] NEG_LIM = {1'b1, {(RW-1){1'b0}}};

  // stage 1: magnitudes and result sign
  logic [AW-1:0] a_u, a_mag_nxt, a_mag_r;
  logic [BW-1:0] b_u, b_mag_nxt, b_mag_r;
  logic          neg1_r;

  always_comb begin
    a_u       = a_i;
    b_u       = b_i;
    a_mag_nxt = a_u[AW-1] ? (~a_u + AW'(1)) : a_u;
    b_mag_nxt = b_u[BW-1] ? (~b_u + BW'(1)) : b_u;
  end

  always_ff @(posedge clk) begin
    a_mag_r <= a_mag_nxt;
    b_mag_r <= b_mag_nxt;
    neg1_r  <= a_i[AW-1] ^ b_i[BW-1];
  end

  // stage 2: 32x32 partial products
  logic [NA*CW-1:0] a_pad;
  logic [NB*CW-1:0] b_pad;
  logic [2*CW-1:0]  pp_nxt [NA*NB];
  logic [2*CW-1:0]  pp_r   [NA*NB];
  logic             neg2_r;

  always_comb begin
    a_pad = (NA*CW)'(a_mag_r);
    b_pad = (NB*CW)'(b_mag_r);
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i*NB+j] = a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NA*NB; k++) begin
      pp_r[k] <= pp_nxt[k];
    end
    neg2_r <= neg1_r;
  end

  // stage 3: full magnitude product
  logic [PW-1:0] prod_nxt, prod_r;
  logic          neg3_r;

  always_comb begin
    prod_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        prod_nxt = prod_nxt + (PW'(pp_r[i*NB+j]) << (CW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg3_r <= neg2_r;
  end

  // stage 4: round, shift, clip the magnitude
  logic [PW-1:0] rnd, q;
  logic [TW-1:0] q_top;
  logic          over;
  logic [RW-1:0] mag_nxt, mag_r;
  logic          neg4_r;

  always_comb begin
    rnd   = prod_r + HALF;
    q     = rnd >> SHIFT;
    q_top = q[PW-1:RW-1];
    if (neg3_r) begin
      over = (q_top > TW'(1)) || ((q_top == TW'(1)) && (q[RW-2:0] != '0));
    end else begin
      over = (q_top != '0);
    end
    mag_nxt = over ? (neg3_r ? NEG_LIM : POS_LIM) : q[RW-1:0];
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg4_r <= neg3_r;
  end

  // stage 5: apply sign
  logic [RW-1:0] res_nxt, res_r;

  assign res_nxt = neg4_r ? (~mag_r + RW'(1)) : mag_r;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign p_o = $signed(res_r);

endmodule

// ===== src/lde_cfg_regs.sv =====
// Coefficient register file; writes to unknown indexes are dropped.
module lde_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en_i,
  input  logic [lde_pkg::CFG_IDX_W-1:0]    idx_i,
  input  logic [lde_pkg::CFG_DATA_W-1:0]   data_i,
  output lde_pkg::coef_t                   coef_o
);

  localparam int FW = lde_pkg::FIELD_W;

  logic [2*FW-1:0] focal_r, focal_nxt;
  logic [2*FW-1:0] pp_r, pp_nxt;
  logic [FW-1:0]   skew_r, skew_nxt;
  logic [2*FW-1:0] k12_r, k12_nxt;
  logic [FW-1:0]   k3_r, k3_nxt;
  logic [2*FW-1:0] p12_r, p12_nxt;
  logic [FW-1:0]   sr_r, sr_nxt;

  // register write decode
  always_comb begin
    focal_nxt = focal_r;
    pp_nxt    = pp_r;
    skew_nxt  = skew_r;
    k12_nxt   = k12_r;
    k3_nxt    = k3_r;
    p12_nxt   = p12_r;
    sr_nxt    = sr_r;
    if (wr_en_i) begin
      unique case (lde_pkg::cfg_reg_t'(idx_i))
        lde_pkg::REG_FOCAL:     focal_nxt = data_i;
        lde_pkg::REG_PRINCIPAL: pp_nxt    = data_i;
        lde_pkg::REG_SKEW:      skew_nxt  = data_i[FW-1:0];
        lde_pkg::REG_K1K2:      k12_nxt   = data_i;
        lde_pkg::REG_K3:        k3_nxt    = data_i[FW-1:0];
        lde_pkg::REG_P1P2:      p12_nxt   = data_i;
        lde_pkg::REG_SCALE:     sr_nxt    = data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= 64'h0001_0000_0001_0000;
      pp_r    <= '0;
      skew_r  <= '0;
      k12_r   <= '0;
      k3_r    <= '0;
      p12_r   <= '0;
      sr_r    <= 32'h0001_0000;
    end else begin
      focal_r <= focal_nxt;
      pp_r    <= pp_nxt;
      skew_r  <= skew_nxt;
      k12_r   <= k12_nxt;
      k3_r    <= k3_nxt;
      p12_r   <= p12_nxt;
      sr_r    <= sr_nxt;
    end
  end

  // unpack into coefficient fields
  always_comb begin
    coef_o.fx = focal_r[2*FW-1:FW];
    coef_o.fy = focal_r[FW-1:0];
    coef_o.cx = pp_r[2*FW-1:FW];
    coef_o.cy = pp_r[FW-1:0];
    coef_o.sk = skew_r;
    coef_o.k1 = k12_r[2*FW-1:FW];
    coef_o.k2 = k12_r[FW-1:0];
    coef_o.k3 = k3_r;
    coef_o.p1 = p12_r[2*FW-1:FW];
    coef_o.p2 = p12_r[FW-1:0];
    coef_o.sr = sr_r;
  end

endmodule

// ===== src/lde_datapath.sv =====
`include "lens_distort_project_unit_macros.svh"

// Distortion and projection arithmetic. Times below are counted from the
// beat in the input register; every product is a pipelined lde_mulq.
module lde_datapath #(
  parameter int COORD_WIDTH = lde_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld_i,
  input  logic signed [lde_pkg::FIELD_W-1:0]  x_i,
  input  logic signed [lde_pkg::FIELD_W-1:0]  y_i,
  input  logic                                last_i,
  input  lde_pkg::coef_t                      coef_i,
  output logic                                out_valid_o,
  output logic signed [COORD_WIDTH-1:0]       pixel_x_o,
  output logic signed [COORD_WIDTH-1:0]       pixel_y_o,
  output logic                                overflow_o,
  output logic                                last_o
);

  localparam int AW = lde_pkg::ACC_W;
  localparam int FW = lde_pkg::FIELD_W;
  localparam int QN = lde_pkg::FRAC_NORM;
  localparam int QP = lde_pkg::FRAC_PIX;
  localparam int L  = lde_pkg::MUL_LAT;

  // schedule
  localparam int T_RR   = L + 1;
  localparam int T_AX   = T_RR + 2;
  localparam int T_R4   = T_RR + L;
  localparam int T_RAD1 = T_R4 + 1;
  localparam int T_R6   = T_R4 + L;
  localparam int T_RAD2 = T_R6 + 1;
  localparam int T_K3   = T_R6 + L;
  localparam int T_RAD  = T_K3 + 1;
  localparam int T_TAN  = T_AX + L + 1;
  localparam int T_XR   = T_RAD + L;
  localparam int T_XD   = T_XR + 1;
  localparam int T_UV1  = T_XD + L + 1;
  localparam int T_UV   = T_UV1 + 1;
  localparam int T_PIX  = T_UV + L;
  localparam int T_OUT  = T_PIX + 1;

  localparam logic signed [COORD_WIDTH-1:0] PIX_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] PIX_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [AW-1:0] CMAX = AW'(PIX_MAX);
  localparam logic signed [AW-1:0] CMIN = AW'(PIX_MIN);

  // beat valid travels alongside the data
  logic [T_OUT-1:0] vld_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sh_r <= '0;
    end else begin
      vld_sh_r <= {vld_sh_r[T_OUT-2:0], vld_i};
    end
  end

  // squares and cross term
  logic signed [AW-1:0] xx, yy, xy;

  lde_mulq #(.AW(FW), .BW(FW), .SHIFT(QN)) u_m_xx (.clk(clk), .a_i(x_i), .b_i(x_i), .p_o(xx));
  lde_mulq #(.AW(FW), .BW(FW), .SHIFT(QN)) u_m_yy (.clk(clk), .a_i(y_i), .b_i(y_i), .p_o(yy));
  lde_mulq #(.AW(FW), .BW(FW), .SHIFT(QN)) u_m_xy (.clk(clk), .a_i(x_i), .b_i(y_i), .p_o(xy));

  // r^2 and the tangential sums, as a chain of registered adds
  logic signed [AW-1:0] rr_r, xy2_r, xx1_r, yy1_r;
  logic signed [AW-1:0] rxx_r, ryy_r, xx2_r, yy2_r;
  logic signed [AW-1:0] ax_r, ay_r;

  always_ff @(posedge clk) begin
    rr_r  <= lde_pkg::sat_add(xx, yy);
    xy2_r <= lde_pkg::sat_add(xy, xy);
    xx1_r <= xx;
    yy1_r <= yy;
    rxx_r <= lde_pkg::sat_add(rr_r, xx1_r);
    ryy_r <= lde_pkg::sat_add(rr_r, yy1_r);
    xx2_r <= xx1_r;
    yy2_r <= yy1_r;
    ax_r  <= lde_pkg::sat_add(rxx_r, xx2_r);
    ay_r  <= lde_pkg::sat_add(ryy_r, yy2_r);
  end

  // powers of r
  logic signed [AW-1:0] r4, r6, rr_d;

  lde_delay #(.W(AW), .DEPTH(T_R4 - T_RR)) u_d_rr (.clk(clk), .d_i(rr_r), .q_o(rr_d));

  lde_mulq #(.AW(AW), .BW(AW), .SHIFT(QN)) u_m_r4 (.clk(clk), .a_i(rr_r), .b_i(rr_r), .p_o(r4));
  lde_mulq #(.AW(AW), .BW(AW), .SHIFT(QN)) u_m_r6 (.clk(clk), .a_i(r4), .b_i(rr_d), .p_o(r6));

  // radial factor, summed left to right
  logic signed [AW-1:0] k1rr, k2r4, k3r6;
  logic signed [AW-1:0] rad1_r, rad1_d, rad2_r, rad2_d, rad_r;

  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_k1 (.clk(clk), .a_i(coef_i.k1), .b_i(rr_r),
                                                   .p_o(k1rr));
  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_k2 (.clk(clk), .a_i(coef_i.k2), .b_i(r4),
                                                   .p_o(k2r4));
  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_k3 (.clk(clk), .a_i(coef_i.k3), .b_i(r6),
                                                   .p_o(k3r6));

  lde_delay #(.W(AW), .DEPTH(T_R6 - T_RAD1)) u_d_rad1 (.clk(clk), .d_i(rad1_r), .q_o(rad1_d));
  lde_delay #(.W(AW), .DEPTH(T_K3 - T_RAD2)) u_d_rad2 (.clk(clk), .d_i(rad2_r), .q_o(rad2_d));

  always_ff @(posedge clk) begin
    rad1_r <= lde_pkg::sat_add(lde_pkg::ONE_Q28, k1rr);
    rad2_r <= lde_pkg::sat_add(rad1_d, k2r4);
    rad_r  <= lde_pkg::sat_add(rad2_d, k3r6);
  end

  // tangential terms
  logic signed [AW-1:0] xy2_d, p1xy, p2ax, p1ay, p2xy;
  logic signed [AW-1:0] tx_r, ty_r, tx_d, ty_d;

  lde_delay #(.W(AW), .DEPTH(T_AX - T_RR)) u_d_xy2 (.clk(clk), .d_i(xy2_r), .q_o(xy2_d));

  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_t1 (.clk(clk), .a_i(coef_i.p1), .b_i(xy2_d),
                                                   .p_o(p1xy));
  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_t2 (.clk(clk), .a_i(coef_i.p2), .b_i(ax_r),
                                                   .p_o(p2ax));
  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_t3 (.clk(clk), .a_i(coef_i.p1), .b_i(ay_r),
                                                   .p_o(p1ay));
  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_t4 (.clk(clk), .a_i(coef_i.p2), .b_i(xy2_d),
                                                   .p_o(p2xy));

  always_ff @(posedge clk) begin
    tx_r <= lde_pkg::sat_add(p1xy, p2ax);
    ty_r <= lde_pkg::sat_add(p1ay, p2xy);
  end

  lde_delay #(.W(AW), .DEPTH(T_XR - T_TAN)) u_d_tx (.clk(clk), .d_i(tx_r), .q_o(tx_d));
  lde_delay #(.W(AW), .DEPTH(T_XR - T_TAN)) u_d_ty (.clk(clk), .d_i(ty_r), .q_o(ty_d));

  // distorted point
  logic signed [FW-1:0] x_d, y_d;
  logic signed [AW-1:0] xrad, yrad, xd_r, yd_r;

  lde_delay #(.W(FW), .DEPTH(T_RAD)) u_d_x (.clk(clk), .d_i(x_i), .q_o(x_d));
  lde_delay #(.W(FW), .DEPTH(T_RAD)) u_d_y (.clk(clk), .d_i(y_i), .q_o(y_d));

  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_xr (.clk(clk), .a_i(x_d), .b_i(rad_r),
                                                   .p_o(xrad));
  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_yr (.clk(clk), .a_i(y_d), .b_i(rad_r),
                                                   .p_o(yrad));

  always_ff @(posedge clk) begin
    xd_r <= lde_pkg::sat_add(xrad, tx_d);
    yd_r <= lde_pkg::sat_add(yrad, ty_d);
  end

  // intrinsic matrix
  logic signed [FW:0]   fx_s, fy_s, sr_s;
  logic signed [AW-1:0] cx_w, cy_w;
  logic signed [AW-1:0] fxxd, skyd, fyyd;
  logic signed [AW-1:0] u1_r, v1_r, u_r, v_r;

  always_comb begin
    fx_s = $signed({1'b0, coef_i.fx});
    fy_s = $signed({1'b0, coef_i.fy});
    sr_s = $signed({1'b0, coef_i.sr});
    cx_w = $signed({{(AW-FW){coef_i.cx[FW-1]}}, coef_i.cx});
    cy_w = $signed({{(AW-FW){coef_i.cy[FW-1]}}, coef_i.cy});
  end

  lde_mulq #(.AW(FW+1), .BW(AW), .SHIFT(QN)) u_m_fx (.clk(clk), .a_i(fx_s), .b_i(xd_r),
                                                     .p_o(fxxd));
  lde_mulq #(.AW(FW), .BW(AW), .SHIFT(QN)) u_m_sk (.clk(clk), .a_i(coef_i.sk), .b_i(yd_r),
                                                   .p_o(skyd));
  lde_mulq #(.AW(FW+1), .BW(AW), .SHIFT(QN)) u_m_fy (.clk(clk), .a_i(fy_s), .b_i(yd_r),
                                                     .p_o(fyyd));

  always_ff @(posedge clk) begin
    u1_r <= lde_pkg::sat_add(fxxd, skyd);
    v1_r <= lde_pkg::sat_add(fyyd, cy_w);
    u_r  <= lde_pkg::sat_add(u1_r, cx_w);
    v_r  <= v1_r;
  end

  // homogeneous scale
  logic signed [AW-1:0] pu, pv;

  lde_mulq #(.AW(AW), .BW(FW+1), .SHIFT(QP)) u_m_pu (.clk(clk), .a_i(u_r), .b_i(sr_s),
                                                     .p_o(pu));
  lde_mulq #(.AW(AW), .BW(FW+1), .SHIFT(QP)) u_m_pv (.clk(clk), .a_i(v_r), .b_i(sr_s),
                                                     .p_o(pv));

  logic last_d;

  lde_delay #(.W(1), .DEPTH(T_PIX)) u_d_last (.clk(clk), .d_i(last_i), .q_o(last_d));

  // clamp to the pixel word and flag it
  logic                          ox, oy;
  logic signed [COORD_WIDTH-1:0] px_nxt, py_nxt;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic                          ovf_r, last_r;

  always_comb begin
    ox = (pu > CMAX) || (pu < CMIN);
    oy = (pv > CMAX) || (pv < CMIN);
    if (pu > CMAX) begin
      px_nxt = PIX_MAX;
    end else if (pu < CMIN) begin
      px_nxt = PIX_MIN;
    end else begin
      px_nxt = pu[COORD_WIDTH-1:0];
    end
    if (pv > CMAX) begin
      py_nxt = PIX_MAX;
    end else if (pv < CMIN) begin
      py_nxt = PIX_MIN;
    end else begin
      py_nxt = pv[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    ovf_r  <= ox | oy;
    last_r <= last_d;
  end

  assign out_valid_o = vld_sh_r[T_OUT-1];
  assign pixel_x_o   = px_r;
  assign pixel_y_o   = py_r;
  assign overflow_o  = ovf_r;
  assign last_o      = last_r;

  // a result beat always stems from a beat taken through the valid shift line
  `LDE_ASSERT(a_out_from_in, out_valid_o |-> $past(vld_i, T_OUT))
  // a flagged result sits on a bound of the pixel range
  `LDE_ASSERT(a_ovf_at_bound, out_valid_o && overflow_o |-> (pixel_x_o == PIX_MAX || pixel_x_o == PIX_MIN || pixel_y_o == PIX_MAX || pixel_y_o == PIX_MIN))
  // zero reciprocal scale gives the origin without a flag
  `LDE_ASSERT(a_zero_scale, out_valid_o && coef_i.sr == '0 |-> pixel_x_o == '0 && pixel_y_o == '0 && !overflow_o)
  // reset empties the pipeline
  `LDE_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid_o)

endmodule

// ===== src/lens_distort_project_unit.sv =====
// Forward radial/tangential lens distortion and pinhole projection.
//
// Input: a beat is taken at each rising edge with start high and busy low.
// busy never rises, so a new normalized point (Q4.28) may be offered in
// every cycle. in_last_in rides along and comes back as out_last_out.
// Output: out_valid is high for exactly one cycle per point, with the
// Q16.16 pixel coordinates and the overflow flag; the receiver must take
// it then, there is no hold-off.
// Throughput: one point per cycle sustained. The pipeline depth is set by
// seven dependent rounded products (r^2, r^4, r^6, k3 term, x*radial,
// intrinsics, scale) plus the saturating adds between them.
// Configuration: cfg_ready is always high; a write lands at the edge with
// cfg_valid high. Write only while no point is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and loads unit focal
// lengths, unit scale and zero for everything else.
module lens_distort_project_unit #(
  parameter int COORD_WIDTH = lde_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // point channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lde_pkg::FIELD_W-1:0]  in_norm_x,
  input  logic signed [lde_pkg::FIELD_W-1:0]  in_norm_y,
  input  logic                                in_last_in,
  // pixel channel
  output logic                                out_valid,
  output logic signed [COORD_WIDTH-1:0]       out_pixel_x,
  output logic signed [COORD_WIDTH-1:0]       out_pixel_y,
  output logic                                out_overflow,
  output logic                                out_last_out,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lde_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lde_pkg::CFG_DATA_W-1:0]      cfg_data
);

  lde_pkg::coef_t coef;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  lde_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en_i (cfg_valid & cfg_ready),
    .idx_i   (cfg_index),
    .data_i  (cfg_data),
    .coef_o  (coef)
  );

  // input register
  logic                               accept;
  logic                               vld_r;
  logic signed [lde_pkg::FIELD_W-1:0] x_r, y_r;
  logic                               last_r;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_norm_x;
      y_r    <= in_norm_y;
      last_r <= in_last_in;
    end
  end

  lde_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (vld_r),
    .x_i         (x_r),
    .y_i         (y_r),
    .last_i      (last_r),
    .coef_i      (coef),
    .out_valid_o (out_valid),
    .pixel_x_o   (out_pixel_x),
    .pixel_y_o   (out_pixel_y),
    .overflow_o  (out_overflow),
    .last_o      (out_last_out)
  );

endmodule
